### design/bti_pkg.sv
// shared widths and the word that moves through the divider chain
package bti_pkg;

  localparam int COORD_W = 16;
  localparam int SAMPLE_W = 8;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int AREA_W = PROD_W + 1;
  localparam int SDIFF_W = SAMPLE_W + 1;
  localparam int WPROD_W = AREA_W + SDIFF_W;
  localparam int REM_W = 48;
  localparam int DEN_W = AREA_W + 1;
  localparam int QUO_W = SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] VAL_MAX = '1;

  typedef struct packed {
    logic clip;
    logic force_hi;
    logic deg;
  } bti_flags_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    bti_flags_t       flags;
  } bti_div_word_t;

endpackage

### design/bti_front.sv
// edge products, areas, weighted numerator and range check, seven stages
module bti_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex0_x,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex0_y,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex1_x,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex1_y,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex2_x,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex2_y,
  input  logic [bti_pkg::SAMPLE_W-1:0]       sample0,
  input  logic [bti_pkg::SAMPLE_W-1:0]       sample1,
  input  logic [bti_pkg::SAMPLE_W-1:0]       sample2,
  input  logic signed [bti_pkg::COORD_W-1:0] query_x,
  input  logic signed [bti_pkg::COORD_W-1:0] query_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bti_pkg::bti_div_word_t             out_word
);
  import bti_pkg::*;

  localparam int NSTAGE = 7;

  logic [NSTAGE:1] valid;
  logic [NSTAGE:1] ready;

  // stage 1: edge vectors and sample deltas
  logic signed [DIFF_W-1:0]  ax1, ay1, bx1, by1, dx1, dy1;
  logic signed [SDIFF_W-1:0] s0_1, ds1_1, ds2_1;
  // stage 2: cross products
  logic signed [PROD_W-1:0]  p_aby, p_bay, p_dby, p_bdy, p_ady, p_day;
  logic signed [SDIFF_W-1:0] s0_2, ds1_2, ds2_2;
  // stage 3: doubled area and partial areas
  logic signed [AREA_W-1:0]  area3, n1_3, n2_3;
  logic signed [SDIFF_W-1:0] s0_3, ds1_3, ds2_3;
  // stage 4: weighted terms
  logic signed [WPROD_W-1:0] t0, t1, t2;
  logic signed [AREA_W-1:0]  area4;
  // stage 5: numerator
  logic signed [REM_W-1:0]   num5;
  logic signed [AREA_W-1:0]  area5;
  logic                      deg5;
  // stage 6: sign normalized fraction
  logic [REM_W-1:0]          num6;
  logic [DEN_W-1:0]          den6;
  logic                      deg6;
  // stage 7: range check
  bti_div_word_t             word7;

  logic signed [DEN_W-1:0]   area_x;
  logic signed [DEN_W-1:0]   den_s;
  logic [REM_W-1:0]          den255;
  logic                      lo, hi;

  always_comb begin
    ready[NSTAGE] = !valid[NSTAGE] || out_ready;
    for (int i = NSTAGE - 1; i >= 1; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign in_ready  = ready[1];
  assign out_valid = valid[NSTAGE];
  assign out_word  = word7;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[1]) valid[1] <= in_valid;
      for (int i = 2; i <= NSTAGE; i++) begin
        if (ready[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign area_x = DEN_W'(area5);
  assign den_s  = area5[AREA_W-1] ? -area_x : area_x;

  // 255 * den as (den << 8) - den
  assign den255 = REM_W'({den6, {SAMPLE_W{1'b0}}}) - REM_W'(den6);
  assign lo     = num6[REM_W-1];
  assign hi     = !lo && (num6 > den255);

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      ax1   <= DIFF_W'(vertex1_x) - DIFF_W'(vertex0_x);
      ay1   <= DIFF_W'(vertex1_y) - DIFF_W'(vertex0_y);
      bx1   <= DIFF_W'(vertex2_x) - DIFF_W'(vertex0_x);
      by1   <= DIFF_W'(vertex2_y) - DIFF_W'(vertex0_y);
      dx1   <= DIFF_W'(query_x) - DIFF_W'(vertex0_x);
      dy1   <= DIFF_W'(query_y) - DIFF_W'(vertex0_y);
      s0_1  <= $signed({1'b0, sample0});
      ds1_1 <= $signed({1'b0, sample1}) - $signed({1'b0, sample0});
      ds2_1 <= $signed({1'b0, sample2}) - $signed({1'b0, sample0});
    end
    if (ready[2]) begin
      p_aby <= ax1 * by1;
      p_bay <= bx1 * ay1;
      p_dby <= dx1 * by1;
      p_bdy <= bx1 * dy1;
      p_ady <= ax1 * dy1;
      p_day <= dx1 * ay1;
      s0_2  <= s0_1;
      ds1_2 <= ds1_1;
      ds2_2 <= ds2_1;
    end
    if (ready[3]) begin
      area3 <= AREA_W'(p_aby) - AREA_W'(p_bay);
      n1_3  <= AREA_W'(p_dby) - AREA_W'(p_bdy);
      n2_3  <= AREA_W'(p_ady) - AREA_W'(p_day);
      s0_3  <= s0_2;
      ds1_3 <= ds1_2;
      ds2_3 <= ds2_2;
    end
    if (ready[4]) begin
      t0    <= s0_3 * area3;
      t1    <= ds1_3 * n1_3;
      t2    <= ds2_3 * n2_3;
      area4 <= area3;
    end
    if (ready[5]) begin
      num5  <= REM_W'(t0) + REM_W'(t1) + REM_W'(t2);
      area5 <= area4;
      deg5  <= (area4 == '0);
    end
    if (ready[6]) begin
      // negative area: flip both so the denominator is positive
      num6 <= area5[AREA_W-1] ? REM_W'(-num5) : REM_W'(num5);
      den6 <= DEN_W'(den_s);
      deg6 <= deg5;
    end
    if (ready[7]) begin
      word7.rem            <= num6;
      word7.den            <= den6;
      word7.quo            <= '0;
      word7.flags.clip     <= !deg6 && (lo || hi);
      word7.flags.force_hi <= !deg6 && hi;
      word7.flags.deg      <= deg6;
    end
  end

endmodule

### design/bti_div_cell.sv
// one restoring division step: decides quotient bit SHIFT
module bti_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bti_pkg::bti_div_word_t in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bti_pkg::bti_div_word_t out_word
);
  import bti_pkg::*;

  logic          valid;
  bti_div_word_t word;
  bti_div_word_t word_next;
  logic [REM_W-1:0] den_sh;
  logic [REM_W:0]   diff;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  assign den_sh = REM_W'(in_word.den) << SHIFT;
  assign diff   = {1'b0, in_word.rem} - {1'b0, den_sh};

  always_comb begin
    word_next = in_word;
    // no borrow means the shifted divisor fits
    if (!diff[REM_W]) begin
      word_next.rem        = diff[REM_W-1:0];
      word_next.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) word <= word_next;
  end

endmodule

### design/bti_round.sv
// round half to even, saturate, output register
module bti_round (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bti_pkg::bti_div_word_t        in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bti_pkg::SAMPLE_W-1:0]  interp_value,
  output logic                          clipped,
  output logic                          degenerate
);
  import bti_pkg::*;

  logic [DEN_W-1:0]    r;
  logic [DEN_W:0]      twice_r;
  logic                up;
  logic [QUO_W:0]      rounded;
  logic [SAMPLE_W-1:0] value_next;

  assign in_ready = !out_valid || !out_stall;

  // remainder is below the divisor here
  assign r       = in_word.rem[DEN_W-1:0];
  assign twice_r = {r, 1'b0};
  assign up      = (twice_r > {1'b0, in_word.den}) ||
                   ((twice_r == {1'b0, in_word.den}) && in_word.quo[0]);
  assign rounded = {1'b0, in_word.quo} + (QUO_W + 1)'(up);

  always_comb begin
    priority if (in_word.flags.force_hi) begin
      value_next = VAL_MAX;
    end else if (in_word.flags.clip || in_word.flags.deg) begin
      value_next = '0;
    end else if (rounded[QUO_W]) begin
      value_next = VAL_MAX;
    end else begin
      value_next = rounded[QUO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      interp_value <= value_next;
      clipped      <= in_word.flags.clip;
      degenerate   <= in_word.flags.deg;
    end
  end

endmodule

### design/barycentric_triangle_interp_top.sv
// each word goes through the front stages, eight divider cells and the round register
// throughput: one word per cycle unstalled; eight-cell quotient chain, one bit per cell
// a stalled output fills empty stages first, so input keeps flowing while bubbles remain
// reset clears every stage valid bit; the block is ready in the first cycle after reset
module barycentric_triangle_interp_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex0_x,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex0_y,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex1_x,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex1_y,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex2_x,
  input  logic signed [bti_pkg::COORD_W-1:0] vertex2_y,
  input  logic [bti_pkg::SAMPLE_W-1:0]       sample0,
  input  logic [bti_pkg::SAMPLE_W-1:0]       sample1,
  input  logic [bti_pkg::SAMPLE_W-1:0]       sample2,
  input  logic signed [bti_pkg::COORD_W-1:0] query_x,
  input  logic signed [bti_pkg::COORD_W-1:0] query_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bti_pkg::SAMPLE_W-1:0]       interp_value,
  output logic                               clipped,
  output logic                               degenerate
);
  import bti_pkg::*;

  logic          in_ready;
  logic          chain_valid [QUO_W+1];
  logic          chain_ready [QUO_W+1];
  bti_div_word_t chain_word  [QUO_W+1];

  assign in_stall = !in_ready;

  bti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vertex0_x (vertex0_x),
    .vertex0_y (vertex0_y),
    .vertex1_x (vertex1_x),
    .vertex1_y (vertex1_y),
    .vertex2_x (vertex2_x),
    .vertex2_y (vertex2_y),
    .sample0   (sample0),
    .sample1   (sample1),
    .sample2   (sample2),
    .query_x   (query_x),
    .query_y   (query_y),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_word  (chain_word[0])
  );

  // msb of the quotient first
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    bti_div_cell #(
      .SHIFT (QUO_W - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  bti_round u_round (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (chain_valid[QUO_W]),
    .in_ready     (chain_ready[QUO_W]),
    .in_word      (chain_word[QUO_W]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .interp_value (interp_value),
    .clipped      (clipped),
    .degenerate   (degenerate)
  );

endmodule

### design/bti_checker.sv
// port-level checks on the interpolator, bound to the top level
module bti_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bti_pkg::SAMPLE_W-1:0] interp_value,
  input logic                         clipped,
  input logic                         degenerate
);
  import bti_pkg::*;

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> interp_value == '0 && !clipped)
    else $error("degenerate word with nonzero value or clip");

  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> interp_value == '0 || interp_value == VAL_MAX)
    else $error("clipped word not on a rail");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(interp_value) &&
      $stable(clipped) && $stable(degenerate))
    else $error("stalled result word changed");

endmodule

bind barycentric_triangle_interp_top bti_checker u_bti_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .interp_value (interp_value),
  .clipped      (clipped),
  .degenerate   (degenerate)
);
